### rtl/core/ljf_pkg.sv
// ----------------------------------------------------------------------------
// ljf_pkg
// Shared types and constants of the Lennard-Jones (WCA) pair force pipeline.
// ----------------------------------------------------------------------------
package ljf_pkg;

    // data word of the transaction fields and width of the config registers
    localparam int WORD_BITS = 32;
    localparam int REG_W     = WORD_BITS - 1;

    // width of intermediate magnitudes, which are capped at 2^62
    localparam int VAL_W     = 63;

    // multiplier operand width, split into halves for the partial products
    localparam int MUL_W     = 64;
    localparam int HALF_W    = MUL_W / 2;

    localparam logic [VAL_W-1:0] CAP_Q      = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] CAP_DIV4   = CAP_Q >> 2;
    localparam logic [VAL_W-1:0] CAP_DIV48  = CAP_Q / 48;
    localparam logic [VAL_W-1:0] OUT_MAX_Q  =
        {{(VAL_W-REG_W){1'b0}}, {REG_W{1'b1}}};

    localparam logic [REG_W-1:0] BOX_RESET    = REG_W'(1465439);
    localparam logic [REG_W-1:0] CUTOFF_RESET = REG_W'(82570);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_CUTOFF = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] delta_x;
        logic signed [WORD_BITS-1:0] delta_y;
    } lj_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] force_x;
        logic signed [WORD_BITS-1:0] force_y;
        logic        [REG_W-1:0]     pair_energy;
        logic                        within_cut;
    } lj_out_t;

endpackage

### rtl/core/ljf_delay.sv
// ----------------------------------------------------------------------------
// ljf_delay
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module ljf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

### rtl/core/ljf_wmul.sv
// ----------------------------------------------------------------------------
// ljf_wmul
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 products.
// ----------------------------------------------------------------------------
module ljf_wmul (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [ljf_pkg::MUL_W-1:0]   a,
    input  logic [ljf_pkg::MUL_W-1:0]   b,
    output logic [2*ljf_pkg::MUL_W-1:0] p
);
    import ljf_pkg::*;

    logic [MUL_W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*MUL_W-1:0] prod_reg;
    logic [2*MUL_W-1:0] mid_a, mid_b;

    // stage one: partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a[HALF_W-1:0]     * b[HALF_W-1:0];
            lh_reg <= a[HALF_W-1:0]     * b[MUL_W-1:HALF_W];
            hl_reg <= a[MUL_W-1:HALF_W] * b[HALF_W-1:0];
            hh_reg <= a[MUL_W-1:HALF_W] * b[MUL_W-1:HALF_W];
        end
    end

    assign mid_a = {{HALF_W{1'b0}}, lh_reg, {HALF_W{1'b0}}};
    assign mid_b = {{HALF_W{1'b0}}, hl_reg, {HALF_W{1'b0}}};

    // stage two: sum of the aligned partials
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= {hh_reg, ll_reg} + mid_a + mid_b;
        end
    end

    assign p = prod_reg;

endmodule

### rtl/core/ljf_qmul.sv
// ----------------------------------------------------------------------------
// ljf_qmul
// Fixed-point magnitude product, truncated and capped at 2^62, three stages.
// ----------------------------------------------------------------------------
module ljf_qmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [ljf_pkg::VAL_W-1:0] a,
    input  logic [ljf_pkg::VAL_W-1:0] b,
    output logic [ljf_pkg::VAL_W-1:0] p
);
    import ljf_pkg::*;

    localparam int SH_W = 2*MUL_W - FRAC_BITS;

    logic [2*MUL_W-1:0] prod;
    logic [SH_W-1:0]    sh;
    logic [VAL_W-1:0]   p_reg;

    ljf_wmul u_wmul (
        .aclk (aclk),
        .en   (en),
        .a    ({{(MUL_W-VAL_W){1'b0}}, a}),
        .b    ({{(MUL_W-VAL_W){1'b0}}, b}),
        .p    (prod)
    );

    assign sh = prod[2*MUL_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= (sh > {{(SH_W-VAL_W){1'b0}}, CAP_Q}) ? CAP_Q : sh[VAL_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

### rtl/core/ljf_div.sv
// ----------------------------------------------------------------------------
// ljf_div
// Pipelined restoring divider for 2^(2F) / R, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ljf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ljf_pkg::REG_W-1:0]   divisor,
    output logic [2*FRAC_BITS:0]        quotient
);
    import ljf_pkg::*;

    localparam int QW = 2*FRAC_BITS + 1;

    logic [REG_W-1:0] rem_reg [QW];
    logic [REG_W-1:0] dvs_reg [QW];
    logic [QW-1:0]    quo_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [REG_W-1:0] rem_in, dvs_in;
        logic [QW-1:0]    quo_in;
        logic [REG_W:0]   trial, diff;
        logic             dbit, qbit;

        // the dividend is a single one at its top bit
        assign dbit = (i == 0);

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign dvs_in = divisor;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign trial = {rem_in, dbit};
        assign diff  = trial - {1'b0, dvs_in};
        assign qbit  = (trial >= {1'b0, dvs_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= qbit ? diff[REG_W-1:0] : trial[REG_W-1:0];
                dvs_reg[i] <= dvs_in;
                quo_reg[i] <= {quo_in[QW-2:0], qbit};
            end
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

### rtl/core/lennard_jones_pair_force.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force
// throughput: one transaction per cycle, set by the fully pipelined divider
// and multipliers; the whole pipeline holds while a result waits on m_ready
// reset: synchronous active-low aresetn clears all valid bits and loads the
// register defaults (box 1465439, cutoff squared 82570)
// ----------------------------------------------------------------------------
module lennard_jones_pair_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [ljf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ljf_pkg::REG_W-1:0]     cfg_wr_data,
    // pair input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ljf_pkg::lj_in_t               s_data,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output ljf_pkg::lj_out_t              m_data
);
    import ljf_pkg::*;

    localparam int DIV_STAGES = 2*FRAC_BITS + 1;
    // stage at which 1/r^2 becomes available
    localparam int INV_AT     = 5 + DIV_STAGES;
    localparam int LATENCY    = INV_AT + 18;
    localparam logic [VAL_W-1:0] ONE_Q  = {{(VAL_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [VAL_W-1:0] HALF_Q = {{(VAL_W-1){1'b0}}, 1'b1} << (FRAC_BITS-1);
    localparam int SUM_W      = 2*WORD_BITS + 1;
    localparam int RF_W       = SUM_W - FRAC_BITS;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // single periodic wrap of one component
    function automatic logic signed [WORD_BITS:0] wrap_box(
        input logic signed [WORD_BITS-1:0] d,
        input logic        [REG_W-1:0]     box
    );
        logic signed [WORD_BITS+1:0] d_e, d2, b, r;
        d_e = {{2{d[WORD_BITS-1]}}, d};
        d2  = d_e <<< 1;
        b   = {3'b000, box};
        if (d2 >= b) begin
            r = d_e - b;
        end else if (d2 < -b) begin
            r = d_e + b;
        end else begin
            r = d_e;
        end
        return r[WORD_BITS:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] mag_of(input logic signed [WORD_BITS:0] v);
        logic signed [WORD_BITS:0] n;
        n = -v;
        return v[WORD_BITS] ? n[WORD_BITS-1:0] : v[WORD_BITS-1:0];
    endfunction

    // symmetric clamp and sign of a force magnitude
    function automatic logic signed [WORD_BITS-1:0] sat_force(
        input logic [VAL_W-1:0] m,
        input logic             neg
    );
        logic [WORD_BITS-1:0] c;
        c = (m > OUT_MAX_Q) ? OUT_MAX_Q[WORD_BITS-1:0] : m[WORD_BITS-1:0];
        return neg ? -c : c;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] box_x_reg, box_y_reg, cutoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg  <= BOX_RESET;
            box_y_reg  <= BOX_RESET;
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BOX_X:  box_x_reg  <= cfg_wr_data;
                REG_BOX_Y:  box_y_reg  <= cfg_wr_data;
                REG_CUTOFF: cutoff_reg <= cfg_wr_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global pipeline enable: everything moves unless the output holds
    // a result that is not being taken
    // ------------------------------------------------------------------
    logic               en;
    logic [LATENCY-1:0] vld_reg;

    assign en      = !vld_reg[LATENCY-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: wrap into the box
    // ------------------------------------------------------------------
    logic signed [WORD_BITS:0] dxw_reg, dyw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxw_reg <= wrap_box(s_data.delta_x, box_x_reg);
            dyw_reg <= wrap_box(s_data.delta_y, box_y_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes and signs
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] mx_reg, my_reg;
    logic                 negx_reg, negy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg   <= mag_of(dxw_reg);
            my_reg   <= mag_of(dyw_reg);
            negx_reg <= dxw_reg[WORD_BITS];
            negy_reg <= dyw_reg[WORD_BITS];
        end
    end

    // ------------------------------------------------------------------
    // stages 3-4: exact squares
    // ------------------------------------------------------------------
    logic [2*MUL_W-1:0] sqx, sqy;

    ljf_wmul u_sqx (
        .aclk (aclk),
        .en   (en),
        .a    ({{(MUL_W-WORD_BITS){1'b0}}, mx_reg}),
        .b    ({{(MUL_W-WORD_BITS){1'b0}}, mx_reg}),
        .p    (sqx)
    );

    ljf_wmul u_sqy (
        .aclk (aclk),
        .en   (en),
        .a    ({{(MUL_W-WORD_BITS){1'b0}}, my_reg}),
        .b    ({{(MUL_W-WORD_BITS){1'b0}}, my_reg}),
        .p    (sqy)
    );

    // ------------------------------------------------------------------
    // stage 5: r squared, cutoff test
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] r2_sum;
    logic [RF_W-1:0]  r2_full;
    logic [REG_W-1:0] r_reg;
    logic             rzero_reg, inside_reg;

    assign r2_sum  = {1'b0, sqx[2*WORD_BITS-1:0]} + {1'b0, sqy[2*WORD_BITS-1:0]};
    assign r2_full = r2_sum[SUM_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg      <= r2_full[REG_W-1:0];
            rzero_reg  <= (r2_full == '0);
            inside_reg <= (r2_full < {{(RF_W-REG_W){1'b0}}, cutoff_reg});
        end
    end

    // ------------------------------------------------------------------
    // 1/r^2 through the divider; r squared of zero takes the cap
    // ------------------------------------------------------------------
    logic [DIV_STAGES-1:0] quo;
    logic                  rzero_d;
    logic [VAL_W-1:0]      inv, inv_d3, inv_d10;

    ljf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .en       (en),
        .divisor  (r_reg),
        .quotient (quo)
    );

    ljf_delay #(.WIDTH(1), .DEPTH(DIV_STAGES)) u_dly_rzero (
        .aclk (aclk), .en (en), .d (rzero_reg), .q (rzero_d)
    );

    assign inv = rzero_d ? CAP_Q : {{(VAL_W-DIV_STAGES){1'b0}}, quo};

    ljf_delay #(.WIDTH(VAL_W), .DEPTH(3)) u_dly_inv3 (
        .aclk (aclk), .en (en), .d (inv), .q (inv_d3)
    );

    ljf_delay #(.WIDTH(VAL_W), .DEPTH(7)) u_dly_inv10 (
        .aclk (aclk), .en (en), .d (inv_d3), .q (inv_d10)
    );

    // ------------------------------------------------------------------
    // s = inv^3 through two products
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] inv2, s_val;

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_inv2 (
        .aclk (aclk), .en (en), .a (inv), .b (inv), .p (inv2)
    );

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_s (
        .aclk (aclk), .en (en), .a (inv2), .b (inv_d3), .p (s_val)
    );

    // ------------------------------------------------------------------
    // distances of s from one and from one half
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] s_reg, dif1_reg, difh_reg;
    logic             ge1_reg, geh_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= s_val;
            ge1_reg  <= (s_val >= ONE_Q);
            geh_reg  <= (s_val >= HALF_Q);
            dif1_reg <= (s_val >= ONE_Q)  ? s_val - ONE_Q  : ONE_Q - s_val;
            difh_reg <= (s_val >= HALF_Q) ? s_val - HALF_Q : HALF_Q - s_val;
        end
    end

    logic [VAL_W-1:0] pe, pa;

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_pe (
        .aclk (aclk), .en (en), .a (s_reg), .b (dif1_reg), .p (pe)
    );

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_pa (
        .aclk (aclk), .en (en), .a (s_reg), .b (difh_reg), .p (pa)
    );

    // ------------------------------------------------------------------
    // energy: one plus or minus four times the product, clamped
    // ------------------------------------------------------------------
    logic             ge1_d;
    logic [VAL_W-1:0] p4, e_full;
    logic [REG_W-1:0] energy_reg, energy_d;

    ljf_delay #(.WIDTH(1), .DEPTH(3)) u_dly_ge1 (
        .aclk (aclk), .en (en), .d (ge1_reg), .q (ge1_d)
    );

    always_comb begin
        p4 = (pe > CAP_DIV4) ? CAP_Q : {pe[VAL_W-3:0], 2'b00};
        if (ge1_d) begin
            e_full = ONE_Q + p4;
        end else if (p4 >= ONE_Q) begin
            e_full = '0;
        end else begin
            e_full = ONE_Q - p4;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            energy_reg <= (e_full > OUT_MAX_Q) ? OUT_MAX_Q[REG_W-1:0] : e_full[REG_W-1:0];
        end
    end

    ljf_delay #(.WIDTH(REG_W), .DEPTH(6)) u_dly_energy (
        .aclk (aclk), .en (en), .d (energy_reg), .q (energy_d)
    );

    // ------------------------------------------------------------------
    // force factor: 48 * (s(s - 1/2)) * inv, capped
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] fr, fc_reg;

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_fr (
        .aclk (aclk), .en (en), .a (pa), .b (inv_d10), .p (fr)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            fc_reg <= (fr > CAP_DIV48) ? CAP_Q : (fr << 5) + (fr << 4);
        end
    end

    // ------------------------------------------------------------------
    // force components
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] mx_d, my_d;
    logic [VAL_W-1:0]     fmx, fmy;

    ljf_delay #(.WIDTH(2*WORD_BITS), .DEPTH(INV_AT+12)) u_dly_mag (
        .aclk (aclk), .en (en), .d ({mx_reg, my_reg}), .q ({mx_d, my_d})
    );

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_fx (
        .aclk (aclk), .en (en),
        .a    (fc_reg),
        .b    ({{(VAL_W-WORD_BITS){1'b0}}, mx_d}),
        .p    (fmx)
    );

    ljf_qmul #(.FRAC_BITS(FRAC_BITS)) u_fy (
        .aclk (aclk), .en (en),
        .a    (fc_reg),
        .b    ({{(VAL_W-WORD_BITS){1'b0}}, my_d}),
        .p    (fmy)
    );

    // signs and cutoff flag travel alongside
    logic negx_d, negy_d, geh_d, inside_d;

    ljf_delay #(.WIDTH(2), .DEPTH(INV_AT+15)) u_dly_neg (
        .aclk (aclk), .en (en), .d ({negx_reg, negy_reg}), .q ({negx_d, negy_d})
    );

    ljf_delay #(.WIDTH(1), .DEPTH(10)) u_dly_geh (
        .aclk (aclk), .en (en), .d (geh_reg), .q (geh_d)
    );

    ljf_delay #(.WIDTH(1), .DEPTH(INV_AT+12)) u_dly_inside (
        .aclk (aclk), .en (en), .d (inside_reg), .q (inside_d)
    );

    // ------------------------------------------------------------------
    // output register: clamp, sign, and zero everything beyond the cutoff
    // ------------------------------------------------------------------
    lj_out_t m_data_reg, m_data_next;

    always_comb begin
        m_data_next = '0;
        if (inside_d) begin
            // factor is negative below s = one half (attractive side)
            m_data_next.force_x     = sat_force(fmx, !geh_d ^ negx_d);
            m_data_next.force_y     = sat_force(fmy, !geh_d ^ negy_d);
            m_data_next.pair_energy = energy_d;
            m_data_next.within_cut  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = vld_reg[LATENCY-1];

endmodule

### rtl/core/ljf_checker.sv
// ----------------------------------------------------------------------------
// ljf_checker
// Port-level checks of the pair force block, bound to the top level.
// ----------------------------------------------------------------------------
module ljf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input ljf_pkg::lj_out_t              m_data
);
    import ljf_pkg::*;

    // a held result keeps its transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side is stalled exactly when a result is held
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // beyond the cutoff every field is zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.within_cut |->
            m_data.force_x == '0 && m_data.force_y == '0 && m_data.pair_energy == '0)
        else $error("nonzero result beyond cutoff");

endmodule

bind lennard_jones_pair_force ljf_checker u_ljf_checker (.*);

### tb/lj_force_checker.sv
// ----------------------------------------------------------------------------
// lj_force_checker
// Watches the pair and result channels, predicts each result from the pair
// and the register copy, and compares the results in order.
// ----------------------------------------------------------------------------
module lj_force_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ljf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ljf_pkg::REG_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  ljf_pkg::lj_in_t                s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  ljf_pkg::lj_out_t               m_data,
    output int                             fail_count,
    output int                             pending,
    output int                             inside_count,
    output int                             result_count
);
    import ljf_pkg::*;

    localparam int FB = 16;
    localparam logic [127:0] CAP = 128'd1 << 62;
    localparam logic [127:0] ONE = 128'd1 << FB;
    localparam logic [127:0] HALF = 128'd1 << (FB - 1);
    localparam logic [127:0] OMAX = (128'd1 << 31) - 1;

    logic [REG_W-1:0] box_x, box_y, cut_sq;
    lj_out_t expected_q[$];

    initial begin
        fail_count = 0;
        pending = 0;
        inside_count = 0;
        result_count = 0;
    end

    function automatic logic [127:0] fx_mul(logic [127:0] a, logic [127:0] b);
        logic [255:0] p;
        p = (256'(a) * 256'(b)) >> FB;
        return (p > 256'(CAP)) ? CAP : p[127:0];
    endfunction

    function automatic logic [127:0] scale(logic [127:0] v, logic [127:0] k);
        return (v > CAP / k) ? CAP : v * k;
    endfunction

    function automatic longint fold(longint d, longint b);
        if (2 * d >= b) return d - b;
        else if (2 * d < -b) return d + b;
        return d;
    endfunction

    function automatic logic [31:0] clamp_sign(logic [127:0] m, logic neg);
        logic [31:0] v;
        v = (m > OMAX) ? OMAX[31:0] : m[31:0];
        return neg ? -v : v;
    endfunction

    function automatic lj_out_t pair_force(lj_in_t p);
        lj_out_t r;
        longint dx, dy;
        logic [127:0] mx, my, rsq, inv, s, pe, e, a, fc;
        logic neg;
        r = '0;
        dx = fold(longint'(p.delta_x), longint'(box_x));
        dy = fold(longint'(p.delta_y), longint'(box_y));
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        rsq = (mx * mx + my * my) >> FB;
        if (rsq >= 128'(cut_sq)) return r;
        inv = (rsq == 0) ? CAP : (128'd1 << (2 * FB)) / rsq;
        s = fx_mul(fx_mul(inv, inv), inv);
        if (s >= ONE) begin
            e = ONE + scale(fx_mul(s, s - ONE), 4);
        end else begin
            pe = scale(fx_mul(s, ONE - s), 4);
            e = (pe >= ONE) ? 0 : ONE - pe;
        end
        if (e > OMAX) e = OMAX;
        if (s >= HALF) begin
            a = fx_mul(s, s - HALF);
            neg = 1'b0;
        end else begin
            a = fx_mul(s, HALF - s);
            neg = 1'b1;
        end
        fc = scale(fx_mul(a, inv), 48);
        r.force_x = clamp_sign(fx_mul(fc, mx), neg != (dx < 0));
        r.force_y = clamp_sign(fx_mul(fc, my), neg != (dy < 0));
        r.pair_energy = e[REG_W-1:0];
        r.within_cut = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        lj_out_t w;
        if (!aresetn) begin
            box_x <= BOX_RESET;
            box_y <= BOX_RESET;
            cut_sq <= CUTOFF_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BOX_X:  box_x <= cfg_wr_data;
                    REG_BOX_Y:  box_y <= cfg_wr_data;
                    REG_CUTOFF: cut_sq <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                w = pair_force(s_data);
                if (w.within_cut) inside_count++;
                expected_q.push_back(w);
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_data.force_x, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (m_data.force_x !== w.force_x)
                        report_mismatch("force_x", m_data.force_x, w.force_x);
                    if (m_data.force_y !== w.force_y)
                        report_mismatch("force_y", m_data.force_y, w.force_y);
                    if (m_data.pair_energy !== w.pair_energy)
                        report_mismatch("pair_energy", 32'(m_data.pair_energy),
                                        32'(w.pair_energy));
                    if (m_data.within_cut !== w.within_cut)
                        report_mismatch("within_cut", 32'(m_data.within_cut),
                                        32'(w.within_cut));
                end
            end
            // transactions still owed by the block
            pending = expected_q.size();
        end
    end

endmodule

### tb/tb_lennard_jones_pair_force.sv
// ----------------------------------------------------------------------------
// tb_lennard_jones_pair_force
// Drives neighbour pairs with random gaps through several box and cutoff
// settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lennard_jones_pair_force;
    import ljf_pkg::*;

    localparam int LATENCY = 56;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    lj_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lj_out_t m_data;

    int fail_count, pending, inside_count, result_count;
    int idle_cycles = 0;
    bit hold_off = 1'b0;     // long receiver stall requested by stimulus
    bit stim_done = 1'b0;
    int pair_count = 0;

    always #5 aclk = ~aclk;

    lennard_jones_pair_force DUT (.*);

    lj_force_checker checker_i (.*);

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, bursts of steady ready, and one long hold-off
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                g = gap_len();
                m_ready <= (g == 0);
                repeat (g) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one pair at the falling edge, hold until accepted
    task automatic send_pair(logic [31:0] dx, logic [31:0] dy, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_data <= '{delta_x: dx, delta_y: dy};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pair_count++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // a distance mostly near the interaction range, sometimes anywhere
    function automatic logic [31:0] pick_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 32'($signed($urandom_range(0, 160000)) - 80000);
        if (r < 8) return 32'($signed($urandom_range(0, 8000)) - 4000);
        return $urandom;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_pair(pick_delta(), pick_delta(), 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero distance, axis points, the cutoff edge and extremes
        send_pair(32'd0, 32'd0, 1'b0);
        send_pair(32'd0, 32'd65536, 1'b0);
        send_pair(32'd65536, 32'd0, 1'b0);
        send_pair(32'hffff_0000, 32'd0, 1'b0);
        send_pair(32'd72000, 32'd0, 1'b0);
        send_pair(32'd73000, 32'hfffe_e000, 1'b0);
        send_pair(32'd58386, 32'd0, 1'b0);
        send_pair(32'd1, 32'hffff_ffff, 1'b0);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_pair(32'd732719, 32'd732720, 1'b0);
        send_pair(32'hfff4_d1b0, 32'hfff4_d1af, 1'b0);
        send_pair(32'd1465439, 32'd0, 1'b0);
        send_pair(32'd20, 32'hffff_ffec, 1'b0);
        send_pair(32'd40000, 32'd40000, 1'b0);

        // long receiver hold-off while pairs keep coming
        hold_off = 1'b1;
        random_phase(150);
        drain();

        // wide cutoff, tight box: folding and saturation
        write_reg(REG_BOX_X, 31'd65536);
        write_reg(REG_BOX_Y, 31'd200000);
        write_reg(REG_CUTOFF, 31'h7fff_ffff);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_pair(32'd32768, 32'hffff_8000, 1'b0);
        random_phase(150);
        drain();

        // largest box, smallest cutoff
        write_reg(REG_BOX_X, 31'h7fff_ffff);
        write_reg(REG_BOX_Y, 31'h7fff_ffff);
        write_reg(REG_CUTOFF, 31'd65536);
        random_phase(120);
        drain();

        // zero box never folds, mid cutoff
        write_reg(REG_BOX_X, 31'd0);
        write_reg(REG_BOX_Y, 31'd300000);
        write_reg(REG_CUTOFF, 31'd500000);
        random_phase(150);
        drain();

        $display("%0d pairs sent, %0d results checked, %0d inside the cutoff",
                 pair_count, result_count, inside_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### lennard_jones_pair_force.f
rtl/core/ljf_pkg.sv
rtl/core/ljf_delay.sv
rtl/core/ljf_wmul.sv
rtl/core/ljf_qmul.sv
rtl/core/ljf_div.sv
rtl/core/lennard_jones_pair_force.sv
rtl/core/ljf_checker.sv
tb/lj_force_checker.sv
tb/tb_lennard_jones_pair_force.sv
